[hdl/hsep_pkg.sv]
// shared types and constants for the height slice extent profile block
// no dependencies
`timescale 1ns / 1ps

package hsep_pkg;

	localparam int COORD_W        = 20;
	localparam int EXT_W          = 20;
	localparam int CNT_MAX_W      = 17;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int SLICES_DEF     = 10;

	localparam logic signed [COORD_W-1:0] Z_LOW_RESET    = 20'sd102400;
	localparam logic signed [COORD_W-1:0] Z_HIGH_RESET   = -20'sd102400;
	localparam logic [EXT_W-1:0]          MIN_SPAN_RESET = 20'd102;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t               z_low;
		coord_t               z_high;
		logic [CNT_MAX_W-1:0] count;
		logic                 overflow;
	} job_t;

endpackage

[hdl/hsep_front.sv]
// point intake: stores points, tracks z range and count, posts a job per cluster
// depends on hsep_pkg
`timescale 1ns / 1ps

module hsep_front #(
	parameter int MAX_POINTS = hsep_pkg::MAX_POINTS_DEF,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  hsep_pkg::coord_t                px,
	input  hsep_pkg::coord_t                py,
	input  hsep_pkg::coord_t                pz,
	input  logic                            final_point,
	output logic                            job_push,
	output hsep_pkg::job_t                  job,
	input  logic                            job_full,
	input  logic                            mem_release,
	input  logic [AW-1:0]                   rd_addr,
	output logic [3*hsep_pkg::COORD_W-1:0]  rd_data
);
	import hsep_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [3*COORD_W-1:0] mem [MAX_POINTS];
	logic [CW-1:0]        count_q, count_n;
	coord_t               z_low_q, z_high_q, z_low_n, z_high_n;
	logic                 ovf_q, lock_q;
	logic                 accept, room;

	assign full   = lock_q | job_full;
	assign accept = push & ~full;
	assign room   = count_q < CW'(MAX_POINTS);

	always_comb begin
		z_low_n  = z_low_q;
		z_high_n = z_high_q;
		count_n  = count_q;
		if (room) begin
			count_n = count_q + CW'(1);
			if (pz < z_low_q)
				z_low_n = pz;
			if (pz > z_high_q)
				z_high_n = pz;
		end
	end

	assign job_push     = accept & final_point;
	assign job.z_low    = z_low_n;
	assign job.z_high   = z_high_n;
	assign job.count    = CNT_MAX_W'(count_n);
	assign job.overflow = ovf_q | ~room;

	always_ff @(posedge clk) begin
		if (accept && room)
			mem[count_q[AW-1:0]] <= {px, py, pz};
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			z_low_q  <= Z_LOW_RESET;
			z_high_q <= Z_HIGH_RESET;
			ovf_q    <= 1'b0;
			lock_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (final_point) begin
					count_q  <= '0;
					z_low_q  <= Z_LOW_RESET;
					z_high_q <= Z_HIGH_RESET;
					ovf_q    <= 1'b0;
				end else begin
					count_q  <= count_n;
					z_low_q  <= z_low_n;
					z_high_q <= z_high_n;
					ovf_q    <= ovf_q | ~room;
				end
			end
			if (job_push)
				lock_q <= 1'b1;
			else if (mem_release)
				lock_q <= 1'b0;
		end
	end

endmodule

[hdl/hsep_jobq.sv]
// two-entry queue of cluster jobs between intake and slice pass
// depends on hsep_pkg
`timescale 1ns / 1ps

module hsep_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  hsep_pkg::job_t wr_job,
	output logic           q_full,
	output logic           q_valid,
	input  logic           rd,
	output hsep_pkg::job_t rd_job
);
	import hsep_pkg::*;

	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign q_full  = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign rd_job  = ent_q[rp_q];
	assign do_wr   = wr & ~q_full;
	assign do_rd   = rd & q_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr)
				wp_q <= ~wp_q;
			if (do_rd)
				rp_q <= ~rp_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[hdl/hsep_back.sv]
// slice pass: thresholds, per-point slice binning, bounds update, result emission
// depends on hsep_pkg; reads the point memory held in hsep_front
`timescale 1ns / 1ps

module hsep_back #(
	parameter int MAX_POINTS = hsep_pkg::MAX_POINTS_DEF,
	parameter int SLICES     = hsep_pkg::SLICES_DEF,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int SW = $clog2(SLICES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hsep_pkg::EXT_W-1:0]     min_span,
	input  logic                           job_valid,
	output logic                           job_pop,
	input  hsep_pkg::job_t                 job,
	output logic                           mem_release,
	output logic [AW-1:0]                  rd_addr,
	input  logic [3*hsep_pkg::COORD_W-1:0] rd_data,
	output logic                           empty,
	input  logic                           pop,
	output logic [SW-1:0]                  slice_number,
	output logic [hsep_pkg::EXT_W-1:0]     extent_long,
	output logic [hsep_pkg::EXT_W-1:0]     extent_short,
	output logic                           points_dropped,
	output logic                           final_slice
);
	import hsep_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int MW = COORD_W + SW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_PASS  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]         state_q;
	coord_t             z_low_q;
	logic [COORD_W-1:0] span_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q, usable_q;
	logic [MW-1:0]      acc_q, acc_n;
	logic [MW-1:0]      thr_q [1:SLICES-1];
	logic [SW-1:0]      k_q, emit_q;
	logic [AW-1:0]      addr_q;
	logic               last_k, last_addr;

	logic               v_s1, v_s2, v_s3;
	logic [MW-1:0]      m_s2;
	coord_t             x_s2, y_s2, x_s3, y_s3;
	logic [SW-1:0]      idx_s3, idx_n;

	coord_t             xmin_q [SLICES];
	coord_t             xmax_q [SLICES];
	coord_t             ymin_q [SLICES];
	coord_t             ymax_q [SLICES];
	logic [SLICES-1:0]  occ_q;
	logic [SW-1:0]      sel;
	coord_t             xmin_r, xmax_r, ymin_r, ymax_r;

	logic signed [COORD_W:0] span_w, zd, xd, yd;
	logic [COORD_W-1:0]      d_w, ex, ey;
	logic                    usable_w, emit_go;

	logic               out_v_q;

	// job load
	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign span_w   = {job.z_high[COORD_W-1], job.z_high} - {job.z_low[COORD_W-1], job.z_low};
	assign usable_w = !span_w[COORD_W] && (span_w != '0) && (span_w[COORD_W-1:0] >= min_span);

	assign acc_n     = acc_q + MW'(span_q);
	assign last_k    = k_q == SW'(SLICES - 1);
	assign last_addr = (CW'(addr_q) + CW'(1)) == count_q;
	assign rd_addr   = addr_q;

	always_comb begin
		mem_release = 1'b0;
		if (state_q == ST_SETUP && last_k && !(usable_q && count_q != '0))
			mem_release = 1'b1;
		if (state_q == ST_PASS && last_addr)
			mem_release = 1'b1;
	end

	// slice index from the point z
	assign zd  = {rd_data[COORD_W-1], rd_data[COORD_W-1:0]} - {z_low_q[COORD_W-1], z_low_q};
	assign d_w = zd[COORD_W] ? '0 : zd[COORD_W-1:0];

	always_comb begin
		idx_n = '0;
		for (int k = 1; k < SLICES; k++) begin
			if (thr_q[k] <= m_s2)
				idx_n = idx_n + SW'(1);
		end
	end

	// bounds read: emission index or update index
	assign sel    = (state_q == ST_EMIT) ? emit_q : idx_s3;
	assign xmin_r = xmin_q[sel];
	assign xmax_r = xmax_q[sel];
	assign ymin_r = ymin_q[sel];
	assign ymax_r = ymax_q[sel];

	assign xd = {xmax_r[COORD_W-1], xmax_r} - {xmin_r[COORD_W-1], xmin_r};
	assign yd = {ymax_r[COORD_W-1], ymax_r} - {ymin_r[COORD_W-1], ymin_r};
	assign ex = occ_q[sel] ? xd[COORD_W-1:0] : '0;
	assign ey = occ_q[sel] ? yd[COORD_W-1:0] : '0;

	assign emit_go = (state_q == ST_EMIT) && (!out_v_q || pop);
	assign empty   = !out_v_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			z_low_q  <= job.z_low;
			span_q   <= span_w[COORD_W-1:0];
			count_q  <= job.count[CW-1:0];
			ovf_q    <= job.overflow;
			usable_q <= usable_w;
		end
		if (state_q == ST_SETUP)
			thr_q[k_q] <= acc_n;

		m_s2   <= MW'(d_w) * MW'(SLICES);
		x_s2   <= rd_data[3*COORD_W-1:2*COORD_W];
		y_s2   <= rd_data[2*COORD_W-1:COORD_W];
		idx_s3 <= idx_n;
		x_s3   <= x_s2;
		y_s3   <= y_s2;

		if (v_s3) begin
			if (!occ_q[idx_s3] || x_s3 < xmin_r)
				xmin_q[idx_s3] <= x_s3;
			if (!occ_q[idx_s3] || x_s3 > xmax_r)
				xmax_q[idx_s3] <= x_s3;
			if (!occ_q[idx_s3] || y_s3 < ymin_r)
				ymin_q[idx_s3] <= y_s3;
			if (!occ_q[idx_s3] || y_s3 > ymax_r)
				ymax_q[idx_s3] <= y_s3;
		end

		if (emit_go) begin
			slice_number   <= emit_q;
			extent_long    <= (ex > ey) ? ex : ey;
			extent_short   <= (ex > ey) ? ey : ex;
			points_dropped <= ovf_q;
			final_slice    <= emit_q == SW'(SLICES - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			k_q     <= '0;
			addr_q  <= '0;
			emit_q  <= '0;
			occ_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_PASS;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3)
				occ_q[idx_s3] <= 1'b1;

			if (emit_go)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						acc_q   <= '0;
						k_q     <= SW'(1);
						occ_q   <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					acc_q <= acc_n;
					k_q   <= k_q + SW'(1);
					if (last_k) begin
						addr_q <= '0;
						emit_q <= '0;
						if (usable_q && count_q != '0)
							state_q <= ST_PASS;
						else
							state_q <= ST_EMIT;
					end
				end
				ST_PASS: begin
					addr_q <= addr_q + AW'(1);
					if (last_addr)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						emit_q <= emit_q + SW'(1);
						if (emit_q == SW'(SLICES - 1))
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/height_slice_extent_profile_top.sv]
// top level of the height slice extent profile block: config register and wiring
// depends on hsep_pkg, hsep_front, hsep_jobq, hsep_back
`timescale 1ns / 1ps

// Points of a cluster are taken one per cycle while full is low and written to
// a MAX_POINTS-entry point memory while the z range is tracked. The transfer
// that carries final_point queues the job for the slice pass: the job is taken,
// the SLICES-1 slice thresholds are built, each stored point is read, one per
// cycle, through the single read port of the point memory, the three-stage
// binning pipeline drains, then SLICES results are offered one per cycle while
// they are popped. Intake stalls (full high) after the final point until the
// pass has read the last stored point. Results that are not popped hold the
// next slice pass back. A cluster whose z span is below min_span skips the
// point pass, stalls intake until the thresholds are built and gives zero
// extents. Points beyond MAX_POINTS are dropped and flagged on every result of
// that cluster.

module height_slice_extent_profile_top #(
	parameter int MAX_POINTS = hsep_pkg::MAX_POINTS_DEF,
	parameter int SLICES     = hsep_pkg::SLICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [hsep_pkg::EXT_W-1:0]   cfg_data,
	input  logic                         push,
	output logic                         full,
	input  hsep_pkg::coord_t             px,
	input  hsep_pkg::coord_t             py,
	input  hsep_pkg::coord_t             pz,
	input  logic                         final_point,
	output logic                         empty,
	input  logic                         pop,
	output logic [$clog2(SLICES)-1:0]    slice_number,
	output logic [hsep_pkg::EXT_W-1:0]   extent_long,
	output logic [hsep_pkg::EXT_W-1:0]   extent_short,
	output logic                         points_dropped,
	output logic                         final_slice
);
	import hsep_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic [EXT_W-1:0]     min_span_q;
	logic                 job_push, job_full, job_valid, job_pop, mem_release;
	job_t                 job_in, job_out;
	logic [AW-1:0]        rd_addr;
	logic [3*COORD_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_span_q <= MIN_SPAN_RESET;
		else if (cfg_write)
			min_span_q <= cfg_data;
	end

	hsep_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.px          (px),
		.py          (py),
		.pz          (pz),
		.final_point (final_point),
		.job_push    (job_push),
		.job         (job_in),
		.job_full    (job_full),
		.mem_release (mem_release),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	hsep_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_push),
		.wr_job  (job_in),
		.q_full  (job_full),
		.q_valid (job_valid),
		.rd      (job_pop),
		.rd_job  (job_out)
	);

	hsep_back #(
		.MAX_POINTS(MAX_POINTS),
		.SLICES    (SLICES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.min_span       (min_span_q),
		.job_valid      (job_valid),
		.job_pop        (job_pop),
		.job            (job_out),
		.mem_release    (mem_release),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.empty          (empty),
		.pop            (pop),
		.slice_number   (slice_number),
		.extent_long    (extent_long),
		.extent_short   (extent_short),
		.points_dropped (points_dropped),
		.final_slice    (final_slice)
	);

endmodule

[verif/height_slice_extent_profile_top_tb.sv]
// self-checking testbench for height_slice_extent_profile_top: clusters of points in,
// ten slice extents per cluster out, checked against an in-bench slice profile predictor
// depends on hsep_pkg and height_slice_extent_profile_top
`timescale 1ns / 1ps

module height_slice_extent_profile_top_tb;

	import hsep_pkg::*;

	localparam int SLICES     = SLICES_DEF;
	localparam int MAX_POINTS = MAX_POINTS_DEF;
	localparam int SETTLE     = 2 * SLICES + 10;
	localparam int PHASE_ITEMS = 125;

	typedef struct {
		logic [3:0]       slice_idx;
		logic [EXT_W-1:0] ext_long;
		logic [EXT_W-1:0] ext_short;
		logic             dropped;
		logic             top;
	} slice_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [EXT_W-1:0] cfg_data = '0;
	logic             push = 1'b0;
	logic             full;
	coord_t           px = '0;
	coord_t           py = '0;
	coord_t           pz = '0;
	logic             final_point = 1'b0;
	logic             empty;
	logic             pop = 1'b0;
	logic [3:0]       slice_number;
	logic [EXT_W-1:0] extent_long;
	logic [EXT_W-1:0] extent_short;
	logic             points_dropped;
	logic             final_slice;

	// predictor state
	coord_t           pt_x [MAX_POINTS];
	coord_t           pt_y [MAX_POINTS];
	coord_t           pt_z [MAX_POINTS];
	int               stored = 0;
	coord_t           z_lo = Z_LOW_RESET;
	coord_t           z_hi = Z_HIGH_RESET;
	bit               overflowed = 1'b0;
	logic [EXT_W-1:0] min_span_cfg = MIN_SPAN_RESET;

	slice_result_t    expected_slices [$];
	int               mismatches = 0;
	int               points_sent = 0;
	int               clusters_sent = 0;
	int               slices_checked = 0;
	int               send_idle_pct = 21;
	int               recv_idle_pct = 77;

	height_slice_extent_profile_top #(
		.MAX_POINTS(MAX_POINTS),
		.SLICES(SLICES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.px(px),
		.py(py),
		.pz(pz),
		.final_point(final_point),
		.empty(empty),
		.pop(pop),
		.slice_number(slice_number),
		.extent_long(extent_long),
		.extent_short(extent_short),
		.points_dropped(points_dropped),
		.final_slice(final_slice)
	);

	always #1 clk = ~clk;

	function automatic void profile_point(coord_t x, coord_t y, coord_t z, bit last);
		longint        span, d, idx, ex, ey;
		bit            usable;
		bit            occ [SLICES];
		coord_t        xmin [SLICES];
		coord_t        xmax [SLICES];
		coord_t        ymin [SLICES];
		coord_t        ymax [SLICES];
		slice_result_t r;
		if (stored < MAX_POINTS) begin
			pt_x[stored] = x;
			pt_y[stored] = y;
			pt_z[stored] = z;
			stored++;
			if (z < z_lo)
				z_lo = z;
			if (z > z_hi)
				z_hi = z;
		end else begin
			overflowed = 1'b1;
		end
		if (!last)
			return;
		span = longint'(z_hi) - longint'(z_lo);
		usable = span > 0 && span >= longint'(min_span_cfg);
		foreach (occ[s])
			occ[s] = 1'b0;
		if (usable) begin
			for (int i = 0; i < stored; i++) begin
				d = longint'(pt_z[i]) - longint'(z_lo);
				if (d < 0)
					d = 0;
				idx = (SLICES * d) / span;
				if (idx > SLICES - 1)
					idx = SLICES - 1;
				if (!occ[idx]) begin
					occ[idx] = 1'b1;
					xmin[idx] = pt_x[i];
					xmax[idx] = pt_x[i];
					ymin[idx] = pt_y[i];
					ymax[idx] = pt_y[i];
				end else begin
					if (pt_x[i] < xmin[idx]) xmin[idx] = pt_x[i];
					if (pt_x[i] > xmax[idx]) xmax[idx] = pt_x[i];
					if (pt_y[i] < ymin[idx]) ymin[idx] = pt_y[i];
					if (pt_y[i] > ymax[idx]) ymax[idx] = pt_y[i];
				end
			end
		end
		for (int s = 0; s < SLICES; s++) begin
			ex = 0;
			ey = 0;
			if (usable && occ[s]) begin
				ex = longint'(xmax[s]) - longint'(xmin[s]);
				ey = longint'(ymax[s]) - longint'(ymin[s]);
			end
			r.slice_idx = 4'(s);
			r.ext_long  = EXT_W'((ex > ey) ? ex : ey);
			r.ext_short = EXT_W'((ex > ey) ? ey : ex);
			r.dropped   = overflowed;
			r.top       = (s == SLICES - 1);
			expected_slices.insert(expected_slices.size(), r);
		end
		stored = 0;
		z_lo = Z_LOW_RESET;
		z_hi = Z_HIGH_RESET;
		overflowed = 1'b0;
		clusters_sent++;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		slice_result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_slices.size() == 0) begin
				$error("slice result with nothing expected: slice %0d", slice_number);
				mismatches++;
			end else begin
				want = expected_slices.pop_front();
				check_field("slice_number", 32'(want.slice_idx), 32'(slice_number));
				check_field("extent_long", 32'(want.ext_long), 32'(extent_long));
				check_field("extent_short", 32'(want.ext_short), 32'(extent_short));
				check_field("points_dropped", 32'(want.dropped), 32'(points_dropped));
				check_field("final_slice", 32'(want.top), 32'(final_slice));
				slices_checked++;
			end
		end
	end

	always @(posedge clk)
		pop <= ($urandom_range(0, 99) >= recv_idle_pct);

	task automatic send_point(coord_t x, coord_t y, coord_t z, bit last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		px <= x;
		py <= y;
		pz <= z;
		final_point <= last;
		do
			@(posedge clk);
		while (full);
		profile_point(x, y, z, last);
		points_sent++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_slices.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_min_span(logic [EXT_W-1:0] value);
		drain_results();
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		min_span_cfg = value;
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom_range(0, 20'hFFFFF));
	endfunction

	// reset threshold of 0.1 m: one span just below, one exactly on it
	task automatic test_default_threshold();
		send_point(20'sd100, -20'sd50, 20'sd0, 1'b0);
		send_point(20'sd300, 20'sd70, 20'sd101, 1'b1);
		send_point(20'sd100, -20'sd50, 20'sd0, 1'b0);
		send_point(20'sd900, 20'sd70, 20'sd51, 1'b0);
		send_point(-20'sd300, 20'sd10, 20'sd102, 1'b1);
	endtask

	task automatic test_corner_clusters();
		// full-scale coordinates and the widest z span
		send_point(-20'sd524288, 20'sd524287, -20'sd524288, 1'b0);
		send_point(20'sd524287, -20'sd524288, 20'sd524287, 1'b0);
		send_point(20'sd0, 20'sd0, -20'sd524288, 1'b0);
		send_point(-20'sd1, 20'sd1, 20'sd524287, 1'b1);
		// lone point above +100 m lands in the top slice
		send_point(20'sd4000, 20'sd5000, 20'sd200000, 1'b1);
		// all points below -100 m
		send_point(20'sd10, 20'sd20, -20'sd300000, 1'b0);
		send_point(20'sd2000, -20'sd20, -20'sd200000, 1'b1);
		// lone point inside the trackers: zero span
		send_point(20'sd77, 20'sd88, 20'sd0, 1'b1);
		// equal extents, empty middle slices
		send_point(20'sd0, 20'sd0, 20'sd0, 1'b0);
		send_point(20'sd1024, 20'sd1024, 20'sd0, 1'b0);
		send_point(20'sd5, 20'sd5, 20'sd10240, 1'b1);
	endtask

	task automatic test_threshold_extremes();
		set_min_span('0);
		send_point(20'sd1, 20'sd2, 20'sd500, 1'b0);
		send_point(20'sd3, 20'sd9, 20'sd500, 1'b1);
		send_point(20'sd1, 20'sd2, 20'sd500, 1'b0);
		send_point(20'sd3, 20'sd9, 20'sd501, 1'b1);
		set_min_span(20'hFFFFF);
		send_point(20'sd5, -20'sd5, -20'sd524288, 1'b0);
		send_point(-20'sd5, 20'sd6, 20'sd524287, 1'b1);
		send_point(20'sd5, -20'sd5, -20'sd524287, 1'b0);
		send_point(-20'sd5, 20'sd6, 20'sd524287, 1'b1);
		set_min_span(MIN_SPAN_RESET);
	endtask

	task automatic random_cluster(output int count);
		int     mode, base, w;
		coord_t x, y, z;
		mode = $urandom_range(0, 4);
		count = (mode == 3) ? 1 : $urandom_range(2, 16);
		base = int'($urandom_range(0, 800000)) - 400000;
		w = $urandom_range(0, 4096);
		for (int i = 0; i < count; i++) begin
			x = rand_coord();
			y = rand_coord();
			z = rand_coord();
			case (mode)
				1: begin
					z = coord_t'(base + int'($urandom_range(0, w)));
				end
				2: begin
					x = coord_t'(int'($urandom_range(0, 7)) * 1024 - 4096);
					y = $urandom_range(0, 1) ? x : coord_t'(int'($urandom_range(0, 7)) * 1024);
					z = coord_t'(int'($urandom_range(0, 9)) * 1024);
				end
				4: begin
					z = coord_t'(base);
				end
				default: ;
			endcase
			send_point(x, y, z, i == count - 1);
		end
	endtask

	task automatic test_random_phase(int sender_idle, int receiver_idle, logic [EXT_W-1:0] span_cfg);
		int done, n;
		set_min_span(span_cfg);
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		done = 0;
		while (done < PHASE_ITEMS) begin
			random_cluster(n);
			done += n;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_threshold();
		test_corner_clusters();
		test_threshold_extremes();
		test_random_phase(21, 77, 20'(int'($urandom_range(0, 4096))));
		test_random_phase(77, 21, 20'(int'($urandom_range(0, 4096))));
		test_random_phase(0, 0, MIN_SPAN_RESET);
		drain_results();
		if (expected_slices.size() != 0) begin
			$error("%0d slice results never arrived", expected_slices.size());
			mismatches++;
		end
		$display("sent %0d points in %0d clusters, checked %0d slice results",
			points_sent, clusters_sent, slices_checked);
		$display("thresholds 0, 102, full scale and random; corner clusters and three idle mixes");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d slice results outstanding", expected_slices.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

[height_slice_extent_profile_top.f]
hdl/hsep_pkg.sv
hdl/hsep_front.sv
hdl/hsep_jobq.sv
hdl/hsep_back.sv
hdl/height_slice_extent_profile_top.sv
verif/height_slice_extent_profile_top_tb.sv
